// ----- rtl/vgn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgn_pkg
// Shared types and codes of the volume gradient normals unit.
// ----------------------------------------------------------------------------
package vgn_pkg;

    // request kinds
    typedef logic [1:0] t_op;
    localparam t_op OP_START = 2'd0;
    localparam t_op OP_LOAD  = 2'd1;
    localparam t_op OP_READ  = 2'd2;
    localparam t_op OP_NONE  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z   = 3'd5;

    // neighbour present flags
    localparam int NB_XP = 0;
    localparam int NB_XM = 1;
    localparam int NB_YP = 2;
    localparam int NB_YM = 3;
    localparam int NB_ZP = 4;
    localparam int NB_ZM = 5;

    // widest store address over the whole dimension range
    localparam int ADDR_MAX_W = 30;

    typedef struct packed {
        t_op                   op;
        logic [ADDR_MAX_W-1:0] addr;
        logic [15:0]           sample;
        logic [5:0]            nb;
    } t_cmd;

    typedef struct packed {
        logic [15:0] inv_x;
        logic [15:0] inv_y;
        logic [15:0] inv_z;
    } t_spacing;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } t_qstat;

endpackage

// ----- rtl/volume_gradient_normals_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_gradient_normals_unit
// Voxel store with density normalisation and central difference normals.
// ----------------------------------------------------------------------------
// A beat is taken when i_start is high and o_busy low; beats other than none
// and out-of-range loads go into a two entry queue and run in order. Start
// and load beats are done as they leave the queue. A read runs the seven
// neighbour fetches from the single read port, the scaled differences and
// their squares, the square root and five divisions on the one shared
// bit-serial divider; with a zero gradient four divisions drop out. A
// degenerate range answers in the cycle after the read leaves the queue.
// Each result shows on the outputs for one cycle with o_valid; there is no
// way to hold it off. The store is not cleared after reset.
module volume_gradient_normals_unit import vgn_pkg::*; #(
    parameter int MAX_DIM_X = 64,
    parameter int MAX_DIM_Y = 64,
    parameter int MAX_DIM_Z = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_req_type,
    input  logic [5:0]           i_pos_x,
    input  logic [5:0]           i_pos_y,
    input  logic [5:0]           i_pos_z,
    input  logic [15:0]          i_sample,
    output logic                 o_valid,
    output logic [15:0]          o_density,
    output logic signed [15:0]   o_normal_x,
    output logic signed [15:0]   o_normal_y,
    output logic signed [15:0]   o_normal_z,
    output logic [23:0]          o_grad_magnitude,
    output logic                 o_degenerate
);
    localparam int DEPTH  = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              w_push, w_pop, w_we;
    t_cmd              w_cmd_in, w_cmd_out;
    t_qstat            w_qstat;
    t_spacing          w_spacing;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [15:0]       w_wdata, w_rdata;

    vgn_front #(
        .MAX_DIM_X (MAX_DIM_X),
        .MAX_DIM_Y (MAX_DIM_Y),
        .MAX_DIM_Z (MAX_DIM_Z)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_start    (i_start),
        .i_full     (w_qstat.full),
        .i_req_type (i_req_type),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_sample   (i_sample),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in),
        .o_spacing  (w_spacing)
    );

    vgn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_stat  (w_qstat)
    );

    vgn_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    vgn_back #(
        .MAX_DIM_X (MAX_DIM_X),
        .MAX_DIM_Y (MAX_DIM_Y),
        .ADDR_W    (ADDR_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd_out),
        .i_empty          (w_qstat.empty),
        .i_spacing        (w_spacing),
        .o_pop            (w_pop),
        .o_we             (w_we),
        .o_waddr          (w_waddr),
        .o_wdata          (w_wdata),
        .o_raddr          (w_raddr),
        .i_rdata          (w_rdata),
        .o_valid          (o_valid),
        .o_density        (o_density),
        .o_normal_x       (o_normal_x),
        .o_normal_y       (o_normal_y),
        .o_normal_z       (o_normal_z),
        .o_grad_magnitude (o_grad_magnitude),
        .o_degenerate     (o_degenerate)
    );

    assign o_busy = w_qstat.full;

`ifndef SYNTH
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_density == 16'd0 && o_normal_x == 16'sd0
            && o_normal_y == 16'sd0 && o_normal_z == 16'sd0 && o_grad_magnitude == 24'd0)
        else $error("degenerate result with non-zero fields");

    a_unit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_normal_x <= 16'sd16384 && o_normal_x >= -16'sd16384
            && o_normal_y <= 16'sd16384 && o_normal_y >= -16'sd16384
            && o_normal_z <= 16'sd16384 && o_normal_z >= -16'sd16384)
        else $error("normal component beyond unit length");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= 2'd2 && !(w_pop && w_qstat.empty))
        else $error("command queue over or underflow");
`endif
endmodule

// ----- rtl/vgn_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgn_ram
// Simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module vgn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/vgn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgn_front
// Configuration registers and request decode: range checks, coordinate
// clamping, border flags and store address of each accepted beat.
// ----------------------------------------------------------------------------
module vgn_front import vgn_pkg::*; #(
    parameter int MAX_DIM_X = 64,
    parameter int MAX_DIM_Y = 64,
    parameter int MAX_DIM_Z = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_start,
    input  logic                 i_full,
    input  logic [1:0]           i_req_type,
    input  logic [5:0]           i_pos_x,
    input  logic [5:0]           i_pos_y,
    input  logic [5:0]           i_pos_z,
    input  logic [15:0]          i_sample,
    output logic                 o_push,
    output t_cmd                 o_cmd,
    output t_spacing             o_spacing
);
    logic [6:0]  r_dim_x, r_dim_y, r_dim_z;
    logic [15:0] r_inv_x, r_inv_y, r_inv_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= 7'd64;
            r_dim_y <= 7'd64;
            r_dim_z <= 7'd64;
            r_inv_x <= 16'd305;
            r_inv_y <= 16'd256;
            r_inv_z <= 16'd400;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIM_X: r_dim_x <= i_cfg_data[6:0];
                CFG_DIM_Y: r_dim_y <= i_cfg_data[6:0];
                CFG_DIM_Z: r_dim_z <= i_cfg_data[6:0];
                CFG_INV_X: r_inv_x <= i_cfg_data;
                CFG_INV_Y: r_inv_y <= i_cfg_data;
                CFG_INV_Z: r_inv_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_spacing = '{inv_x: r_inv_x, inv_y: r_inv_y, inv_z: r_inv_z};

    function automatic logic [10:0] eff_dim(input logic [6:0] d, input logic [10:0] maxd);
        logic [10:0] w;
        w = {4'b0, d};
        if (d == 7'd0) return 11'd1;
        return (w > maxd) ? maxd : w;
    endfunction

    logic [10:0] w_ex, w_ey, w_ez;
    logic [10:0] w_px, w_py, w_pz;
    logic [10:0] w_cx, w_cy, w_cz;
    logic        w_in_range;
    logic [31:0] w_addr;

    always_comb begin
        w_ex = eff_dim(r_dim_x, 11'(MAX_DIM_X));
        w_ey = eff_dim(r_dim_y, 11'(MAX_DIM_Y));
        w_ez = eff_dim(r_dim_z, 11'(MAX_DIM_Z));
        w_px = {5'b0, i_pos_x};
        w_py = {5'b0, i_pos_y};
        w_pz = {5'b0, i_pos_z};
        w_in_range = (w_px < w_ex) && (w_py < w_ey) && (w_pz < w_ez);
        // reads saturate to the last voxel in use
        w_cx = (w_px >= w_ex) ? w_ex - 11'd1 : w_px;
        w_cy = (w_py >= w_ey) ? w_ey - 11'd1 : w_py;
        w_cz = (w_pz >= w_ez) ? w_ez - 11'd1 : w_pz;
        w_addr = ({21'b0, w_cz} * 32'(MAX_DIM_Y) + {21'b0, w_cy}) * 32'(MAX_DIM_X)
                 + {21'b0, w_cx};

        o_cmd.op     = i_req_type;
        o_cmd.addr   = w_addr[ADDR_MAX_W-1:0];
        o_cmd.sample = i_sample;
        o_cmd.nb[NB_XP] = (w_cx + 11'd1) < w_ex;
        o_cmd.nb[NB_XM] = (w_cx != 11'd0);
        o_cmd.nb[NB_YP] = (w_cy + 11'd1) < w_ey;
        o_cmd.nb[NB_YM] = (w_cy != 11'd0);
        o_cmd.nb[NB_ZP] = (w_cz + 11'd1) < w_ez;
        o_cmd.nb[NB_ZM] = (w_cz != 11'd0);

        o_push = i_start && !i_full && (i_req_type != OP_NONE)
                 && !((i_req_type == OP_LOAD) && !w_in_range);
    end
endmodule

// ----- rtl/vgn_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgn_queue
// Two entry command queue between decode and execution.
// ----------------------------------------------------------------------------
module vgn_queue import vgn_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_cmd,
    output t_qstat o_stat
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_stat.count = r_count;
endmodule

// ----- rtl/vgn_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgn_back
// Command execution: range trackers, voxel writes, neighbour fetch, gradient
// squares, bit-pair square root and a shared bit-serial divider.
// ----------------------------------------------------------------------------
module vgn_back import vgn_pkg::*; #(
    parameter int MAX_DIM_X = 64,
    parameter int MAX_DIM_Y = 64,
    parameter int ADDR_W    = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_empty,
    input  t_spacing           i_spacing,
    output logic               o_pop,
    output logic               o_we,
    output logic [ADDR_W-1:0]  o_waddr,
    output logic [15:0]        o_wdata,
    output logic [ADDR_W-1:0]  o_raddr,
    input  logic [15:0]        i_rdata,
    output logic               o_valid,
    output logic [15:0]        o_density,
    output logic signed [15:0] o_normal_x,
    output logic signed [15:0] o_normal_y,
    output logic signed [15:0] o_normal_z,
    output logic [23:0]        o_grad_magnitude,
    output logic               o_degenerate
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FETCH = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_SQ    = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_DSET  = 4'd5;
    localparam logic [3:0] ST_DRUN  = 4'd6;
    localparam logic [3:0] ST_DEND  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic [ADDR_W-1:0] STRIDE_X = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(MAX_DIM_X);
    localparam logic [ADDR_W-1:0] STRIDE_Z = ADDR_W'(MAX_DIM_X * MAX_DIM_Y);

    localparam logic [5:0] DIV_STEPS = 6'd48;

    logic [3:0]        r_state, n_state;
    logic [5:0]        r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [5:0]        r_nb, n_nb;
    logic [15:0]       r_vox [7];
    logic [15:0]       n_vox [7];
    logic [30:0]       r_a [3];
    logic [30:0]       n_a [3];
    logic [2:0]        r_neg, n_neg;
    logic [63:0]       r_sum, n_sum;
    logic [63:0]       r_root, n_root;
    logic [63:0]       r_bit, n_bit;
    logic [2:0]        r_j, n_j;
    logic [47:0]       r_num, n_num;
    logic [49:0]       r_rem, n_rem;
    logic [49:0]       r_den, n_den;
    logic [15:0]       r_dens, n_dens;
    logic [15:0]       r_nrm [3];
    logic [15:0]       n_nrm [3];
    logic [23:0]       r_mag, n_mag;
    logic [15:0]       r_min, n_min;
    logic [15:0]       r_max, n_max;
    logic              r_valid, n_valid;
    logic              r_degen, n_degen;

    logic [15:0] w_range;
    logic [15:0] w_nxt, w_prv, w_inv, w_d;
    logic [31:0] w_prod;
    logic [61:0] w_sq;
    logic [63:0] w_trial;
    logic [49:0] w_t;
    logic        w_ge;
    logic [15:0] w_n;
    logic [1:0]  w_k;

    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;   n_addr = r_addr;  n_nb = r_nb;
        n_vox   = r_vox;    n_a   = r_a;     n_neg  = r_neg;   n_sum = r_sum;
        n_root  = r_root;   n_bit = r_bit;   n_j    = r_j;     n_num = r_num;
        n_rem   = r_rem;    n_den = r_den;   n_dens = r_dens;  n_nrm = r_nrm;
        n_mag   = r_mag;    n_min = r_min;   n_max  = r_max;
        n_valid = 1'b0;     n_degen = r_degen;

        o_pop   = 1'b0;
        o_we    = 1'b0;
        o_waddr = i_cmd.addr[ADDR_W-1:0];
        o_wdata = i_cmd.sample;
        o_raddr = r_addr;

        w_range = r_max - r_min;
        w_k     = r_cnt[1:0];
        case (w_k)
            2'd0:    begin w_nxt = r_vox[1]; w_prv = r_vox[2]; w_inv = i_spacing.inv_x; end
            2'd1:    begin w_nxt = r_vox[3]; w_prv = r_vox[4]; w_inv = i_spacing.inv_y; end
            default: begin w_nxt = r_vox[5]; w_prv = r_vox[6]; w_inv = i_spacing.inv_z; end
        endcase
        w_d     = (w_nxt < w_prv) ? w_prv - w_nxt : w_nxt - w_prv;
        w_prod  = {16'b0, w_d} * {16'b0, w_inv};
        w_sq    = 62'(r_a[w_k]) * 62'(r_a[w_k]);
        w_trial = r_root + r_bit;
        w_t     = {r_rem[48:0], r_num[47]};
        w_ge    = (w_t >= r_den);
        w_n     = r_num[15:0];

        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_START: begin
                            n_min = 16'hFFFF;
                            n_max = 16'h0000;
                        end
                        OP_LOAD: begin
                            o_we = 1'b1;
                            if (i_cmd.sample > r_max) n_max = i_cmd.sample;
                            if (i_cmd.sample < r_min) n_min = i_cmd.sample;
                        end
                        OP_READ: begin
                            n_dens = '0;
                            n_nrm  = '{default: '0};
                            n_mag  = '0;
                            if (r_max <= r_min) begin
                                n_valid = 1'b1;
                                n_degen = 1'b1;
                            end else begin
                                n_degen = 1'b0;
                                n_addr  = i_cmd.addr[ADDR_W-1:0];
                                n_nb    = i_cmd.nb;
                                n_cnt   = '0;
                                n_state = ST_FETCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                // one address per cycle, data lands in the following cycle
                case (r_cnt[2:0])
                    3'd0:    o_raddr = r_addr;
                    3'd1:    o_raddr = r_nb[NB_XP] ? r_addr + STRIDE_X : r_addr;
                    3'd2:    o_raddr = r_nb[NB_XM] ? r_addr - STRIDE_X : r_addr;
                    3'd3:    o_raddr = r_nb[NB_YP] ? r_addr + STRIDE_Y : r_addr;
                    3'd4:    o_raddr = r_nb[NB_YM] ? r_addr - STRIDE_Y : r_addr;
                    3'd5:    o_raddr = r_nb[NB_ZP] ? r_addr + STRIDE_Z : r_addr;
                    3'd6:    o_raddr = r_nb[NB_ZM] ? r_addr - STRIDE_Z : r_addr;
                    default: o_raddr = r_addr;
                endcase
                if (r_cnt != 6'd0) begin
                    n_vox[3'(r_cnt[2:0] - 3'd1)] = i_rdata;
                end
                if (r_cnt == 6'd7) begin
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_MUL: begin
                n_a[w_k]   = w_prod[31:1];
                n_neg[w_k] = (w_nxt < w_prv);
                if (r_cnt == 6'd2) begin
                    n_cnt   = '0;
                    n_sum   = '0;
                    n_state = ST_SQ;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_SQ: begin
                n_sum = r_sum + {2'b0, w_sq};
                if (r_cnt == 6'd2) begin
                    n_cnt   = '0;
                    n_root  = '0;
                    n_bit   = 64'd1 << 62;
                    n_state = ST_SQRT;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_SQRT: begin
                if (r_sum >= w_trial) begin
                    n_sum  = r_sum - w_trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_cnt == 6'd31) begin
                    n_j     = '0;
                    n_state = ST_DSET;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_DSET: begin
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DRUN;
                case (r_j)
                    3'd0: begin
                        n_num = {16'b0, r_vox[0] - r_min, 16'b0};
                        n_den = {34'b0, w_range};
                        if (r_vox[0] <= r_min) n_state = ST_DSET;
                    end
                    3'd1, 3'd2, 3'd3: begin
                        n_num = {2'b0, r_a[2'(r_j - 3'd1)], 15'b0} + {16'b0, r_root[31:0]};
                        n_den = {17'b0, r_root[31:0], 1'b0};
                        if (r_root == 64'd0) n_state = ST_DSET;
                    end
                    default: begin
                        n_num = {9'b0, r_root[31:0], 7'b0};
                        n_den = {34'b0, w_range};
                        if (r_root == 64'd0) n_state = ST_DSET;
                    end
                endcase
                // skipped division: its result stays zero
                if (n_state == ST_DSET) begin
                    if (r_j == 3'd4) n_state = ST_OUT;
                    else n_j = r_j + 3'd1;
                end
            end
            ST_DRUN: begin
                n_rem = w_ge ? w_t - r_den : w_t;
                n_num = {r_num[46:0], w_ge};
                if (r_cnt == DIV_STEPS - 6'd1) n_state = ST_DEND;
                else n_cnt = r_cnt + 6'd1;
            end
            ST_DEND: begin
                case (r_j)
                    3'd0: n_dens = (|r_num[47:16]) ? 16'hFFFF : r_num[15:0];
                    3'd1, 3'd2, 3'd3: begin
                        n_nrm[2'(r_j - 3'd1)] = r_neg[2'(r_j - 3'd1)] ? 16'd0 - w_n : w_n;
                    end
                    default: n_mag = (|r_num[47:24]) ? 24'hFFFFFF : r_num[23:0];
                endcase
                if (r_j == 3'd4) begin
                    n_state = ST_OUT;
                end else begin
                    n_j     = r_j + 3'd1;
                    n_state = ST_DSET;
                end
            end
            ST_OUT: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_j     <= '0;
            r_min   <= 16'hFFFF;
            r_max   <= 16'h0000;
            r_valid <= 1'b0;
            r_degen <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_j     <= n_j;
            r_min   <= n_min;
            r_max   <= n_max;
            r_valid <= n_valid;
            r_degen <= n_degen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_nb   <= n_nb;
        r_vox  <= n_vox;
        r_a    <= n_a;
        r_neg  <= n_neg;
        r_sum  <= n_sum;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_dens <= n_dens;
        r_nrm  <= n_nrm;
        r_mag  <= n_mag;
    end

    assign o_valid          = r_valid;
    assign o_density        = r_dens;
    assign o_normal_x       = r_nrm[0];
    assign o_normal_y       = r_nrm[1];
    assign o_normal_z       = r_nrm[2];
    assign o_grad_magnitude = r_mag;
    assign o_degenerate     = r_degen;
endmodule

// ----- bench/tb_volume_gradient_normals_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_volume_gradient_normals_unit
// Drives start, load and read beats into the gradient normals unit and checks
// every read result against a bit-exact predictor of the voxel store, range
// trackers, density normalisation and central difference normals.
// ----------------------------------------------------------------------------
module tb_volume_gradient_normals_unit;
    import vgn_pkg::*;

    typedef struct {
        bit [15:0] density;
        bit [15:0] nx;
        bit [15:0] ny;
        bit [15:0] nz;
        bit [23:0] mag;
        bit        degen;
    } t_voxel_result;

    class normals_scoreboard;
        bit [15:0]     voxels [int];
        bit [15:0]     min_seen;
        bit [15:0]     max_seen;
        bit [6:0]      dim [3];
        bit [15:0]     inv [3];
        t_voxel_result expected_q [$];
        int            errors;

        function void clear();
            min_seen = 16'hFFFF;
            max_seen = 16'h0;
            dim[0] = 64; dim[1] = 64; dim[2] = 64;
            inv[0] = 305; inv[1] = 256; inv[2] = 400;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [15:0] val);
            case (idx)
                CFG_DIM_X: dim[0] = val[6:0];
                CFG_DIM_Y: dim[1] = val[6:0];
                CFG_DIM_Z: dim[2] = val[6:0];
                CFG_INV_X: inv[0] = val;
                CFG_INV_Y: inv[1] = val;
                CFG_INV_Z: inv[2] = val;
                default: ;
            endcase
        endfunction

        function int span(int a);
            if (dim[a] == 0) return 1;
            return (dim[a] > 64) ? 64 : dim[a];
        endfunction

        function bit [15:0] voxel_at(int x, int y, int z);
            int a;
            a = (z * 64 + y) * 64 + x;
            return voxels.exists(a) ? voxels[a] : 16'h0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // half of the scaled difference, sign returned apart
        function longint unsigned half_diff(bit [15:0] nxt, bit [15:0] prv, bit [15:0] sc,
                                            output bit neg);
            longint unsigned d;
            neg = nxt < prv;
            d = neg ? longint'(prv - nxt) : longint'(nxt - prv);
            return (d * sc) >> 1;
        endfunction

        function bit [15:0] unit_comp(longint unsigned a, longint unsigned r, bit neg);
            longint unsigned n;
            n = (a * 32768 + r) / (2 * r);
            return neg ? 16'(-n) : 16'(n);
        endfunction

        function void note_request(t_op op, int x, int y, int z, bit [15:0] s);
            t_voxel_result res;
            int dx, dy, dz;
            longint unsigned rng, a [3], r, m;
            bit neg [3];
            bit [15:0] v;
            dx = span(0); dy = span(1); dz = span(2);
            res = '{default: 0};
            case (op)
                OP_START: begin
                    min_seen = 16'hFFFF;
                    max_seen = 16'h0;
                end
                OP_LOAD: begin
                    if (x < dx && y < dy && z < dz) begin
                        voxels[(z * 64 + y) * 64 + x] = s;
                        if (s > max_seen) max_seen = s;
                        if (s < min_seen) min_seen = s;
                    end
                end
                OP_READ: begin
                    if (max_seen <= min_seen) begin
                        res.degen = 1'b1;
                    end else begin
                        if (x >= dx) x = dx - 1;
                        if (y >= dy) y = dy - 1;
                        if (z >= dz) z = dz - 1;
                        rng = max_seen - min_seen;
                        v = voxel_at(x, y, z);
                        if (v > min_seen) begin
                            m = (longint'(v - min_seen) << 16) / rng;
                            res.density = (m > 65535) ? 16'hFFFF : m[15:0];
                        end
                        a[0] = half_diff(voxel_at(x + 1 < dx ? x + 1 : x, y, z),
                                         voxel_at(x > 0 ? x - 1 : x, y, z), inv[0], neg[0]);
                        a[1] = half_diff(voxel_at(x, y + 1 < dy ? y + 1 : y, z),
                                         voxel_at(x, y > 0 ? y - 1 : y, z), inv[1], neg[1]);
                        a[2] = half_diff(voxel_at(x, y, z + 1 < dz ? z + 1 : z),
                                         voxel_at(x, y, z > 0 ? z - 1 : z), inv[2], neg[2]);
                        r = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                        if (r != 0) begin
                            res.nx = unit_comp(a[0], r, neg[0]);
                            res.ny = unit_comp(a[1], r, neg[1]);
                            res.nz = unit_comp(a[2], r, neg[2]);
                            m = (r * 128) / rng;
                            res.mag = (m > 24'hFFFFFF) ? 24'hFFFFFF : m[23:0];
                        end
                    end
                    expected_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void mismatch(string fld, longint unsigned exp_v, longint unsigned act_v);
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fld, exp_v, act_v);
        endfunction

        function void check_result(t_voxel_result act);
            t_voxel_result e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none actual density %0h",
                         $time, act.density);
                return;
            end
            e = expected_q.pop_front();
            if (act.density != e.density) mismatch("density", e.density, act.density);
            if (act.nx != e.nx) mismatch("normal_x", e.nx, act.nx);
            if (act.ny != e.ny) mismatch("normal_y", e.ny, act.ny);
            if (act.nz != e.nz) mismatch("normal_z", e.nz, act.nz);
            if (act.mag != e.mag) mismatch("grad_magnitude", e.mag, act.mag);
            if (act.degen != e.degen) mismatch("degenerate", e.degen, act.degen);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0]          i_cfg_data;
    logic                 i_start;
    logic                 o_busy;
    logic [1:0]           i_req_type;
    logic [5:0]           i_pos_x;
    logic [5:0]           i_pos_y;
    logic [5:0]           i_pos_z;
    logic [15:0]          i_sample;
    logic                 o_valid;
    logic [15:0]          o_density;
    logic signed [15:0]   o_normal_x;
    logic signed [15:0]   o_normal_y;
    logic signed [15:0]   o_normal_z;
    logic [23:0]          o_grad_magnitude;
    logic                 o_degenerate;

    normals_scoreboard sb;
    bit                calm;
    int                cycles;

    volume_gradient_normals_unit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_voxel_result act;
        if (i_rst_n && o_valid) begin
            act.density = o_density;
            act.nx      = o_normal_x;
            act.ny      = o_normal_y;
            act.nz      = o_normal_z;
            act.mag     = o_grad_magnitude;
            act.degen   = o_degenerate;
            sb.check_result(act);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(t_op op, int x, int y, int z, bit [15:0] s);
        i_start    = 1'b1;
        i_req_type = op;
        i_pos_x    = x[5:0];
        i_pos_y    = y[5:0];
        i_pos_z    = z[5:0];
        i_sample   = s;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        sb.note_request(op, x, y, z, s);
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 15) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_start = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        // loads and starts leave no result, let the queue drain
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [15:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_volume(bit [15:0] dx, bit [15:0] dy, bit [15:0] dz,
                              bit [15:0] sx, bit [15:0] sy, bit [15:0] sz);
        write_reg(CFG_DIM_X, dx);
        write_reg(CFG_DIM_Y, dy);
        write_reg(CFG_DIM_Z, dz);
        write_reg(CFG_INV_X, sx);
        write_reg(CFG_INV_Y, sy);
        write_reg(CFG_INV_Z, sz);
    endtask

    task automatic fill_volume();
        for (int z = 0; z < sb.span(2); z++)
            for (int y = 0; y < sb.span(1); y++)
                for (int x = 0; x < sb.span(0); x++)
                    send_beat(OP_LOAD, x, y, z, 16'($urandom));
    endtask

    function automatic bit [15:0] pick_spacing();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int pick;
        sb = new();
        sb.clear();
        cycles     = 0;
        calm       = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_DIM_X;
        i_cfg_data = 16'h0;
        i_start    = 1'b0;
        i_req_type = OP_NONE;
        i_pos_x    = 6'h0;
        i_pos_y    = 6'h0;
        i_pos_z    = 6'h0;
        i_sample   = 16'h0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // nothing loaded yet: degenerate without touching the store
        send_beat(OP_READ, 63, 63, 63, 16'hFFFF);
        send_beat(OP_NONE, 63, 63, 63, 16'hFFFF);
        wait_idle();
        set_volume(4, 1, 1, 256, 16'hFFFF, 1);
        send_beat(OP_LOAD, 0, 0, 0, 16'h0000);
        send_beat(OP_LOAD, 1, 0, 0, 16'h0007);
        send_beat(OP_LOAD, 2, 0, 0, 16'h0007);
        send_beat(OP_LOAD, 3, 0, 0, 16'h0007);
        send_beat(OP_LOAD, 5, 0, 0, 16'hFFFF);   // outside, ignored
        send_beat(OP_LOAD, 0, 1, 0, 16'hFFFF);
        send_beat(OP_READ, 2, 0, 0, 16'h0);      // flat neighbourhood
        send_beat(OP_READ, 0, 0, 0, 16'h0);
        send_beat(OP_READ, 63, 63, 63, 16'h0);   // clamped to the corner
        send_beat(OP_LOAD, 3, 0, 0, 16'hFFFF);
        send_beat(OP_READ, 2, 0, 0, 16'h0);
        send_beat(OP_READ, 3, 0, 0, 16'h0);
        send_beat(OP_START, 0, 0, 0, 16'h0);
        send_beat(OP_READ, 1, 0, 0, 16'h0);
        send_beat(OP_LOAD, 1, 0, 0, 16'h0007);
        send_beat(OP_READ, 1, 0, 0, 16'h0);      // single value, empty range
        send_beat(OP_LOAD, 0, 0, 0, 16'h0000);
        send_beat(OP_READ, 1, 0, 0, 16'h0);
        wait_idle();
        write_reg(CFG_INV_X, 16'h0);
        send_beat(OP_READ, 1, 0, 0, 16'h0);
        send_beat(OP_READ, 3, 0, 0, 16'h0);

        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            calm = (ph == 4);
            case (ph)
                0: set_volume(127, 1, 0, pick_spacing(), pick_spacing(), pick_spacing());
                1: set_volume(1, 64, 1, pick_spacing(), pick_spacing(), pick_spacing());
                2: set_volume(0, 2, 64, pick_spacing(), pick_spacing(), pick_spacing());
                default: set_volume(16'($urandom_range(1, 5)), 16'($urandom_range(1, 5)),
                                    16'($urandom_range(1, 5)), pick_spacing(),
                                    pick_spacing(), pick_spacing());
            endcase
            send_beat(OP_START, 0, 0, 0, 16'h0);
            fill_volume();
            for (int i = 0; i < 35; i++) begin
                pick = $urandom_range(99);
                if (pick < 55)
                    send_beat(OP_READ, $urandom_range(63), $urandom_range(63),
                              $urandom_range(63), 16'($urandom));
                else if (pick < 80)
                    send_beat(OP_LOAD, $urandom_range(sb.span(0) - 1),
                              $urandom_range(sb.span(1) - 1),
                              $urandom_range(sb.span(2) - 1), 16'($urandom));
                else if (pick < 88)
                    send_beat(OP_LOAD, $urandom_range(63), $urandom_range(63),
                              $urandom_range(63), 16'($urandom));
                else if (pick < 95)
                    send_beat(OP_START, $urandom_range(63), $urandom_range(63),
                              $urandom_range(63), 16'($urandom));
                else
                    send_beat(OP_NONE, $urandom_range(63), $urandom_range(63),
                              $urandom_range(63), 16'($urandom));
            end
        end

        i_start = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/vgn_pkg.sv
rtl/vgn_ram.sv
rtl/vgn_front.sv
rtl/vgn_queue.sv
rtl/vgn_back.sv
rtl/volume_gradient_normals_unit.sv
bench/tb_volume_gradient_normals_unit.sv
